[sv/refcounted_page_allocator_unit_macros.svh]
// Assertion macros shared by the page allocator RTL.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define RPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page allocator assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define RPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page allocator assertion failed");
`else
`define RPA_ASSERT_NOW(lbl, ante, cons)
`define RPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/rpa_pkg.sv]
// Constants, codes and shared types of the page allocator.
package rpa_pkg;

    localparam int NUM_PAGES   = 32768;
    localparam int PAGE_BYTES  = 4096;
    localparam int COUNT_BITS  = 16;

    localparam int ADDR_W      = 32;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int IDX_W       = $clog2(NUM_PAGES);
    localparam int DEPTH_W     = IDX_W + 1;
    localparam int FIRST_W     = ADDR_W - PAGE_SHIFT + 1;
    localparam int ALU_W       = ADDR_W + 1;
    localparam int CNT_OUT_W   = 16;
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 56;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_COUNT   = 4;

    localparam logic [ALU_W-1:0] CAP_BYTES  = ALU_W'(NUM_PAGES) << PAGE_SHIFT;
    localparam logic [ALU_W-1:0] PAGE_MASK  = ALU_W'(PAGE_BYTES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [ADDR_W-1:0] MEM_BASE_RST   = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h8010_0000;
    localparam logic [ADDR_W-1:0] FREE_START_RST = 32'h8010_0000;
    localparam logic [ADDR_W-1:0] MEM_TOP_RST    = 32'h8800_0000;

    localparam logic [CFG_INDEX_W-1:0] REG_MEM_BASE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_END = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FREE_START = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MEM_TOP    = 8'd3;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INC   = 2'd2,
        OP_DEC   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_BADADDR = 3'd2,
        STAT_UNDER   = 3'd3,
        STAT_OVER    = 3'd4
    } status_t;

    // Request to the shared adder: a + b, or a - b when sub is set.
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    // flag is the borrow of a subtraction or the carry of an addition.
    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             flag;
    } alu_rsp_t;

endpackage

[sv/rpa_alu.sv]
// Shared 33-bit add/subtract unit used by the allocator sequencer.
module rpa_alu
    import rpa_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] sum;

    assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
               + {{ALU_W{1'b0}}, req.sub};

    always_comb
    begin
        rsp.value = sum[ALU_W-1:0];
        // A subtraction without carry out means a < b.
        rsp.flag  = req.sub ? ~sum[ALU_W] : sum[ALU_W];
    end

endmodule

[sv/refcounted_page_allocator_unit.sv]
// Top level of the reference-counted page allocator.
//
//  Channel  | Direction | Signals                              | Beat carries
//  ---------+-----------+--------------------------------------+----------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser    | one request: op, address
//  m_       | out       | m_tvalid m_tready m_tdata            | one result per request
//  cfg_     | in        | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
// An alloc steps through pop, pop-data and done (an empty stack skips pop-data); free,
// inc_ref and dec_ref step through base, kernel, check, update and done (a bad address
// skips update). The steps are set by the shared adder, which the sequencer uses for
// each address compare, and by the registered read of the count or stack memory.
// After reset and after every write to a mapped register the block steps through the
// window arithmetic and then sweeps all 32768 entries of both memories, one entry a
// cycle; s_tready stays low until the sweep is over.
// The result sits in an output register, so a stalled m_ side holds only the
// finishing step of the next request, never the acceptance of its beat.
module refcounted_page_allocator_unit
    import rpa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // [31:0] address
    input  logic [IN_USER_W-1:0]   s_tuser,   // [1:0] op

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // [2:0] status, [34:3] page_address,
                                              // [50:35] ref_count_now, [51] page_freed,
                                              // [55:52] zero

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

`include "refcounted_page_allocator_unit_macros.svh"

    typedef enum logic [3:0] {
        S_RB_CAP,
        S_RB_TOP,
        S_RB_SPAN,
        S_RB_FREE,
        S_RB_ROUND,
        S_RB_DEPTH,
        S_SWEEP,
        S_IDLE,
        S_POP,
        S_POP_DATA,
        S_BASE,
        S_KERNEL,
        S_CHECK,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t                 state_reg;

    // Configuration registers.
    logic [ADDR_W-1:0]      mem_base_reg;
    logic [ADDR_W-1:0]      kernel_end_reg;
    logic [ADDR_W-1:0]      free_start_reg;
    logic [ADDR_W-1:0]      mem_top_reg;

    // Window derived from the configuration during a rebuild.
    logic [ALU_W-1:0]       cap_reg;
    logic [ALU_W-1:0]       top_reg;
    logic [ALU_W-1:0]       fs_diff_reg;
    logic [DEPTH_W-1:0]     page_total_reg;
    logic [FIRST_W-1:0]     first_reg;
    logic [IDX_W-1:0]       sweep_reg;
    logic [DEPTH_W-1:0]     depth_reg;

    // Request in flight.
    op_t                    op_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ADDR_W-1:0]      diff_reg;
    logic                   below_base_reg;
    logic                   below_kernel_reg;
    logic [IDX_W-1:0]       idx_reg;
    status_t                status_reg;
    logic [ADDR_W-1:0]      paddr_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic                   freed_reg;

    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    // Memories and their registered read data.
    logic [COUNT_BITS-1:0]  ref_mem [NUM_PAGES];
    logic [IDX_W-1:0]       stk_mem [NUM_PAGES];
    logic [COUNT_BITS-1:0]  ref_rd_reg;
    logic [IDX_W-1:0]       stk_rd_reg;

    logic                   ref_we;
    logic [IDX_W-1:0]       ref_wa;
    logic [COUNT_BITS-1:0]  ref_wd;
    logic                   ref_re;
    logic [IDX_W-1:0]       ref_ra;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_wa;
    logic [IDX_W-1:0]       stk_wd;
    logic                   stk_re;
    logic [IDX_W-1:0]       stk_ra;

    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;

    logic                   in_beat;
    logic                   cfg_beat;
    logic                   cfg_hit;
    logic [FIRST_W-1:0]     page_num;
    logic                   in_range;
    logic                   addr_ok;
    logic                   sweep_reserved;

    logic                   upd_we;
    logic                   upd_push;
    logic [COUNT_BITS-1:0]  upd_val;
    status_t                upd_status;

    assign in_beat   = s_tvalid && s_tready;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_beat && (cfg_index inside {REG_MEM_BASE, REG_KERNEL_END,
                                                      REG_FREE_START, REG_MEM_TOP});
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;

    rpa_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Operand selection for the shared adder: each sequencer step borrows it once.
    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_RB_CAP:
            begin
                alu_req.a = {1'b0, mem_base_reg};
                alu_req.b = CAP_BYTES;
            end
            S_RB_TOP:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, mem_top_reg};
                alu_req.b   = cap_reg;
            end
            S_RB_SPAN:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = top_reg;
                alu_req.b   = {1'b0, mem_base_reg};
            end
            S_RB_FREE:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, free_start_reg};
                alu_req.b   = {1'b0, mem_base_reg};
            end
            S_RB_ROUND:
            begin
                alu_req.a = fs_diff_reg;
                alu_req.b = PAGE_MASK;
            end
            S_RB_DEPTH:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(page_total_reg);
                alu_req.b   = ALU_W'(first_reg);
            end
            S_POP_DATA:
            begin
                alu_req.a = {1'b0, mem_base_reg};
                alu_req.b = ALU_W'(stk_rd_reg) << PAGE_SHIFT;
            end
            S_BASE:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, addr_reg};
                alu_req.b   = {1'b0, mem_base_reg};
            end
            S_KERNEL:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, addr_reg};
                alu_req.b   = {1'b0, kernel_end_reg};
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // Address decode: page number, bounds and, for a free, alignment and the
    // protected kernel region.
    assign page_num = {1'b0, diff_reg[ADDR_W-1:PAGE_SHIFT]};
    assign in_range = !below_base_reg && (page_num < FIRST_W'(page_total_reg));
    assign addr_ok  = (op_reg == OP_FREE)
                    ? (in_range && !below_kernel_reg && (diff_reg[PAGE_SHIFT-1:0] == '0))
                    : in_range;

    // During the sweep a page is reserved when it is managed and lies below the
    // first free page.
    assign sweep_reserved = (DEPTH_W'(sweep_reg) < page_total_reg)
                         && (FIRST_W'(sweep_reg) < first_reg);

    // Count update on the value just read from the count memory.
    always_comb
    begin
        upd_we     = 1'b0;
        upd_push   = 1'b0;
        upd_val    = ref_rd_reg;
        upd_status = STAT_OK;
        case (op_reg)
            OP_FREE:
            begin
                if (ref_rd_reg == '0)
                begin
                    upd_status = STAT_UNDER;
                end
                else
                begin
                    upd_we   = 1'b1;
                    upd_val  = ref_rd_reg - COUNT_BITS'(1);
                    upd_push = (upd_val == '0) && (depth_reg < DEPTH_W'(NUM_PAGES));
                end
            end
            OP_INC:
            begin
                if (ref_rd_reg == CNT_MAX)
                begin
                    upd_status = STAT_OVER;
                end
                else
                begin
                    upd_we  = 1'b1;
                    upd_val = ref_rd_reg + COUNT_BITS'(1);
                end
            end
            OP_DEC:
            begin
                if (ref_rd_reg == '0)
                begin
                    upd_status = STAT_UNDER;
                end
                else
                begin
                    upd_we  = 1'b1;
                    upd_val = ref_rd_reg - COUNT_BITS'(1);
                end
            end
            default:
            begin
                upd_we = 1'b0;
            end
        endcase
    end

    // Memory port control. The sweep owns both write ports while it runs.
    always_comb
    begin
        ref_re = (state_reg == S_CHECK) && addr_ok;
        ref_ra = page_num[IDX_W-1:0];
        stk_re = (state_reg == S_POP) && (depth_reg != '0);
        stk_ra = IDX_W'(depth_reg - DEPTH_W'(1));

        if (state_reg == S_SWEEP)
        begin
            ref_we = 1'b1;
            ref_wa = sweep_reg;
            ref_wd = sweep_reserved ? COUNT_BITS'(1) : '0;
            stk_we = 1'b1;
            stk_wa = sweep_reg;
            stk_wd = IDX_W'(first_reg) + sweep_reg;
        end
        else
        begin
            ref_we = ((state_reg == S_UPDATE) && upd_we) || (state_reg == S_POP_DATA);
            ref_wa = (state_reg == S_POP_DATA) ? stk_rd_reg : idx_reg;
            ref_wd = (state_reg == S_POP_DATA) ? COUNT_BITS'(1) : upd_val;
            stk_we = (state_reg == S_UPDATE) && upd_push;
            stk_wa = depth_reg[IDX_W-1:0];
            stk_wd = idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (ref_re)
        begin
            ref_rd_reg <= ref_mem[ref_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

    // Sequencer, configuration registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_RB_CAP;
            mem_base_reg     <= MEM_BASE_RST;
            kernel_end_reg   <= KERNEL_END_RST;
            free_start_reg   <= FREE_START_RST;
            mem_top_reg      <= MEM_TOP_RST;
            cap_reg          <= '0;
            top_reg          <= '0;
            fs_diff_reg      <= '0;
            page_total_reg   <= '0;
            first_reg        <= '0;
            sweep_reg        <= '0;
            depth_reg        <= '0;
            op_reg           <= OP_ALLOC;
            addr_reg         <= '0;
            diff_reg         <= '0;
            below_base_reg   <= 1'b0;
            below_kernel_reg <= 1'b0;
            idx_reg          <= '0;
            status_reg       <= STAT_OK;
            paddr_reg        <= '0;
            cnt_reg          <= '0;
            freed_reg        <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_data_reg       <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_RB_CAP:
                begin
                    cap_reg   <= alu_rsp.value;
                    state_reg <= S_RB_TOP;
                end
                S_RB_TOP:
                begin
                    // Clamp the top of memory to the capacity of the tables.
                    top_reg   <= alu_rsp.flag ? {1'b0, mem_top_reg} : cap_reg;
                    state_reg <= S_RB_SPAN;
                end
                S_RB_SPAN:
                begin
                    page_total_reg <= alu_rsp.flag ? '0
                                                   : alu_rsp.value[PAGE_SHIFT +: DEPTH_W];
                    state_reg      <= S_RB_FREE;
                end
                S_RB_FREE:
                begin
                    fs_diff_reg <= alu_rsp.value;
                    if (alu_rsp.flag || (alu_rsp.value == '0))
                    begin
                        first_reg <= '0;
                        state_reg <= S_RB_DEPTH;
                    end
                    else
                    begin
                        state_reg <= S_RB_ROUND;
                    end
                end
                S_RB_ROUND:
                begin
                    // Round up to the next page boundary.
                    first_reg <= alu_rsp.value[ALU_W-1:PAGE_SHIFT];
                    state_reg <= S_RB_DEPTH;
                end
                S_RB_DEPTH:
                begin
                    depth_reg <= alu_rsp.flag ? '0 : alu_rsp.value[DEPTH_W-1:0];
                    sweep_reg <= '0;
                    state_reg <= S_SWEEP;
                end
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + IDX_W'(1);
                    if (sweep_reg == IDX_W'(NUM_PAGES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        op_reg     <= op_t'(s_tuser);
                        addr_reg   <= s_tdata;
                        status_reg <= STAT_OK;
                        paddr_reg  <= '0;
                        cnt_reg    <= '0;
                        freed_reg  <= 1'b0;
                        state_reg  <= (op_t'(s_tuser) == OP_ALLOC) ? S_POP : S_BASE;
                    end
                end
                S_POP:
                begin
                    if (depth_reg == '0)
                    begin
                        status_reg <= STAT_EMPTY;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - DEPTH_W'(1);
                        state_reg <= S_POP_DATA;
                    end
                end
                S_POP_DATA:
                begin
                    // The popped page gets a count of one whatever it held.
                    paddr_reg <= alu_rsp.value[ADDR_W-1:0];
                    cnt_reg   <= COUNT_BITS'(1);
                    state_reg <= S_DONE;
                end
                S_BASE:
                begin
                    diff_reg       <= alu_rsp.value[ADDR_W-1:0];
                    below_base_reg <= alu_rsp.flag;
                    state_reg      <= S_KERNEL;
                end
                S_KERNEL:
                begin
                    below_kernel_reg <= alu_rsp.flag;
                    state_reg        <= S_CHECK;
                end
                S_CHECK:
                begin
                    idx_reg <= page_num[IDX_W-1:0];
                    if (addr_ok)
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        status_reg <= STAT_BADADDR;
                        state_reg  <= S_DONE;
                    end
                end
                S_UPDATE:
                begin
                    status_reg <= upd_status;
                    cnt_reg    <= upd_val;
                    freed_reg  <= upd_push;
                    if (upd_push)
                    begin
                        depth_reg <= depth_reg + DEPTH_W'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= OUT_DATA_W'({freed_reg, CNT_OUT_W'(cnt_reg),
                                                     paddr_reg, status_reg});
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_RB_CAP;
                end
            endcase

            // A write to a mapped register rebuilds all tables from the start.
            if (cfg_hit)
            begin
                case (cfg_index)
                    REG_MEM_BASE:   mem_base_reg   <= cfg_data;
                    REG_KERNEL_END: kernel_end_reg <= cfg_data;
                    REG_FREE_START: free_start_reg <= cfg_data;
                    REG_MEM_TOP:    mem_top_reg    <= cfg_data;
                    default:        mem_top_reg    <= mem_top_reg;
                endcase
                state_reg <= S_RB_CAP;
            end
        end
    end

    // The stack depth moves by at most one page a cycle, except when a rebuild
    // loads the count of initially free pages.
    `RPA_ASSERT_NOW(a_depth_step, $past(state_reg) != S_RB_DEPTH, depth_reg == $past(depth_reg) || depth_reg == $past(depth_reg) + DEPTH_W'(1) || depth_reg == $past(depth_reg) - DEPTH_W'(1))
    // One request at a time: after an input beat the block is busy.
    `RPA_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready)
    // A write to a mapped register starts a rebuild, during which no request is taken.
    `RPA_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready && cfg_index < CFG_INDEX_W'(CFG_COUNT), !s_tready)

endmodule

[dv/refcounted_page_allocator_unit_tb.sv]
// Self-checking testbench for the reference-counted page allocator unit.
module refcounted_page_allocator_unit_tb;
    import rpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // An index past the four mapped registers; a write to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd7;

    // One reply beat, unpacked into its fields.
    typedef struct {
        status_t         status;
        logic [31:0]     page_address;
        logic [15:0]     ref_count;
        logic            freed;
    } page_reply_t;

    typedef struct {
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            value;
    } reg_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;    // [31:0] address
    logic [IN_USER_W-1:0]   s_tuser = '0;    // [1:0] op

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;         // [2:0] status, [34:3] page_address,
                                             // [50:35] ref_count_now, [51] page_freed

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data = '0;

    // Mirror of the allocator: window registers, count table and free stack.
    logic [31:0]            win_base;
    logic [31:0]            win_kernel;
    logic [31:0]            win_free;
    logic [31:0]            win_top;
    logic [COUNT_BITS-1:0]  page_refs [NUM_PAGES];
    logic [IDX_W-1:0]       free_pages [NUM_PAGES];
    int unsigned            free_depth;
    int unsigned            page_total;

    page_reply_t            outstanding_replies [$];
    logic [31:0]            held_pages [$];   // recently allocated pages, reused as targets
    reg_write_t             staged_writes [$];
    int unsigned            mismatches = 0;
    bit                     calm = 1'b0;      // set: neither side inserts idle cycles

    refcounted_page_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator mirror
    // ------------------------------------------------------------------

    // Rebuild counts and free stack from the window registers. The effective
    // top is clamped to the capacity above the base; pages below the first
    // page at or above free_start are reserved with a count of one, the rest
    // are pushed in ascending order so the highest page ends up on top.
    function automatic void rebuild_tables();
        logic [32:0] cap;
        logic [32:0] top;
        logic [32:0] first_free;
        int unsigned i;
        cap = {1'b0, win_base} + 33'(NUM_PAGES) * 33'(PAGE_BYTES);
        top = ({1'b0, win_top} < cap) ? {1'b0, win_top} : cap;
        page_total = (top > {1'b0, win_base}) ?
                     32'((top - {1'b0, win_base}) >> PAGE_SHIFT) : 0;
        if (win_free <= win_base)
            first_free = '0;
        else
            first_free = ({1'b0, win_free} - {1'b0, win_base} + 33'(PAGE_BYTES - 1))
                         >> PAGE_SHIFT;
        free_depth = 0;
        for (i = 0; i < NUM_PAGES; i++)
        begin
            if (i < page_total && i < first_free)
                page_refs[i] = 1;
            else
            begin
                page_refs[i] = 0;
                if (i < page_total)
                begin
                    free_pages[free_depth] = IDX_W'(i);
                    free_depth++;
                end
            end
        end
    endfunction

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
        case (index)
            REG_MEM_BASE:   win_base   = value;
            REG_KERNEL_END: win_kernel = value;
            REG_FREE_START: win_free   = value;
            REG_MEM_TOP:    win_top    = value;
            default:        return;   // unmapped index: tables stay as they are
        endcase
        rebuild_tables();
    endfunction

    // True when the address falls inside a whole managed page.
    function automatic bit locate_page(logic [31:0] addr, output int unsigned idx);
        int unsigned k;
        idx = 0;
        if (addr < win_base)
            return 1'b0;
        k = (addr - win_base) >> PAGE_SHIFT;
        if (k >= page_total || k >= NUM_PAGES)
            return 1'b0;
        idx = k;
        return 1'b1;
    endfunction

    // Apply one request to the mirror and return the reply it must produce.
    function automatic page_reply_t compute_reply(op_t op, logic [31:0] addr);
        page_reply_t r;
        int unsigned idx;
        bit          ok;
        r.status = STAT_OK;
        r.page_address = '0;
        r.ref_count = '0;
        r.freed = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                if (free_depth == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // The popped page gets a count of one even if it was nonzero.
                    free_depth--;
                    idx = free_pages[free_depth];
                    page_refs[idx] = 1;
                    r.ref_count = 1;
                    r.page_address = win_base + (32'(idx) << PAGE_SHIFT);
                end
            end
            OP_FREE:
            begin
                ok = addr >= win_base
                     && ((addr - win_base) & 32'(PAGE_BYTES - 1)) == 0
                     && addr >= win_kernel
                     && locate_page(addr, idx);
                if (!ok)
                    r.status = STAT_BADADDR;
                else if (page_refs[idx] == 0)
                    r.status = STAT_UNDER;
                else
                begin
                    page_refs[idx]--;
                    r.ref_count = page_refs[idx];
                    // A full stack silently drops the push.
                    if (page_refs[idx] == 0 && free_depth < NUM_PAGES)
                    begin
                        free_pages[free_depth] = IDX_W'(idx);
                        free_depth++;
                        r.freed = 1'b1;
                    end
                end
            end
            default:
            begin
                // Reference ops need neither alignment nor the kernel_end check.
                if (!locate_page(addr, idx))
                    r.status = STAT_BADADDR;
                else
                begin
                    if (op == OP_INC)
                    begin
                        if (page_refs[idx] == CNT_MAX)
                            r.status = STAT_OVER;
                        else
                            page_refs[idx]++;
                    end
                    else
                    begin
                        // A decrement to zero never returns the page to the stack.
                        if (page_refs[idx] == 0)
                            r.status = STAT_UNDER;
                        else
                            page_refs[idx]--;
                    end
                    r.ref_count = page_refs[idx];
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request beat and record the reply it must produce. tvalid is
    // left high after the beat so back-to-back requests need no second
    // assignment in the same step; idling or a drain lowers it.
    task automatic send_request(op_t op, logic [31:0] addr);
        page_reply_t r;
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = compute_reply(op, addr);
        outstanding_replies.push_back(r);
        if (op == OP_ALLOC && r.status == STAT_OK)
        begin
            held_pages.push_back(r.page_address);
            if (held_pages.size() > 16)
                void'(held_pages.pop_front());
        end
    endtask

    // Stop sending and wait until every outstanding reply has been checked.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (outstanding_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic void stage_write(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
        reg_write_t w;
        w.index = index;
        w.value = value;
        staged_writes.push_back(w);
    endfunction

    // Write the staged registers once the block has gone quiet. Each mapped
    // write triggers a full table rebuild in the block.
    task automatic commit_writes();
        reg_write_t w;
        drain_results();
        while (staged_writes.size() != 0)
        begin
            w = staged_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            apply_register(w.index, w.value);
        end
        cfg_valid <= 1'b0;
        held_pages.delete();
    endtask

    // Pick a target address: mostly pages in play, then managed pages, odd
    // offsets inside pages, window edges, and a share of raw noise.
    function automatic logic [31:0] pick_address();
        int unsigned roll;
        logic [31:0] last_page;
        roll = $urandom_range(0, 99);
        last_page = win_base + ((page_total == 0 ? 0 : page_total - 1) << PAGE_SHIFT);
        if (roll < 45 && held_pages.size() != 0)
            return held_pages[$urandom_range(0, held_pages.size() - 1)];
        if (roll < 65 && page_total != 0)
            return win_base + ($urandom_range(0, page_total - 1) << PAGE_SHIFT);
        if (roll < 75 && page_total != 0)
            return win_base + ($urandom_range(0, page_total - 1) << PAGE_SHIFT)
                   + $urandom_range(1, PAGE_BYTES - 1);
        if (roll < 85)
        begin
            case ($urandom_range(0, 7))
                0: return win_base;
                1: return win_base - PAGE_BYTES;
                2: return win_kernel;
                3: return win_kernel - PAGE_BYTES;
                4: return last_page;
                5: return last_page + PAGE_BYTES;
                6: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // Reply side: random backpressure and field-by-field comparison
    // ------------------------------------------------------------------

    task automatic check_field(string field, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : reply_check
        page_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outstanding_replies.size() == 0)
            begin
                $display("%0t ns: reply beat with nothing outstanding, actual %0h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = outstanding_replies.pop_front();
                check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
                check_field("page_address", want.page_address, m_tdata[34:3]);
                check_field("ref_count_now", 32'(want.ref_count), 32'(m_tdata[50:35]));
                check_field("page_freed", 32'(want.freed), 32'(m_tdata[51]));
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window: pages 0..255 reserved, the rest free with the highest on top.
    task automatic test_basic_ops();
        logic [31:0] top_page;
        top_page = win_base + ((page_total - 1) << PAGE_SHIFT);
        send_request(OP_ALLOC, 32'h0);                  // pops the highest page
        send_request(OP_INC, top_page);
        send_request(OP_DEC, top_page);
        send_request(OP_FREE, top_page);                // back to zero, pushed again
        send_request(OP_DEC, top_page);                 // underflow on a zero count
        send_request(OP_FREE, top_page);                // underflow through free
        send_request(OP_FREE, top_page + 4);            // misaligned
        send_request(OP_FREE, win_kernel - PAGE_BYTES); // below kernel_end
        send_request(OP_FREE, win_base - PAGE_BYTES);   // below the window
        send_request(OP_FREE, win_top);                 // first page past the top
        send_request(OP_INC, win_top);
        send_request(OP_INC, win_base - 1);
        send_request(OP_INC, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h0000_0000);
        send_request(OP_INC, win_base + 32'hFFF);       // reference ops allow any offset
        send_request(OP_DEC, win_base);
        send_request(OP_DEC, win_base);                 // down to zero, not pushed
        send_request(OP_INC, top_page);                 // raise a page still on the stack
        send_request(OP_ALLOC, 32'hFFFF_FFFF);          // pops it; count forced to one
        send_request(OP_FREE, win_kernel);              // first freeable page, count zero
    endtask

    // Drive one reserved page to the counter ceiling and one step past it.
    task automatic test_count_saturation();
        logic [31:0] page;
        page = win_base + PAGE_BYTES;
        calm = 1'b1;
        while (page_refs[1] != CNT_MAX)
            send_request(OP_INC, page);
        send_request(OP_INC, page);
        send_request(OP_DEC, page);
        send_request(OP_FREE, page);
        calm = 1'b0;
    endtask

    task automatic test_random_traffic(int unsigned items);
        int unsigned n;
        int unsigned roll;
        op_t         op;
        for (n = 0; n < items; n++)
        begin
            // A long run without idling on either side, and one full drain.
            calm = (n >= items / 3 && n < items / 3 + items / 5);
            if (n == items / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            op = roll < 30 ? OP_ALLOC : roll < 55 ? OP_FREE : roll < 80 ? OP_INC : OP_DEC;
            send_request(op, pick_address());
        end
        calm = 1'b0;
    endtask

    // Whole window at address zero with every page free: the stack is full.
    task automatic test_full_window();
        stage_write(REG_MEM_BASE, 32'h0000_0000);
        stage_write(REG_KERNEL_END, 32'h0000_0000);
        stage_write(REG_FREE_START, 32'h0000_0000);
        stage_write(REG_MEM_TOP, 32'hFFFF_FFFF);
        commit_writes();
        send_request(OP_INC, 32'h0000_5000);
        send_request(OP_FREE, 32'h0000_5000);   // count hits zero, push dropped
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h07FF_F000);
        send_request(OP_FREE, 32'h0000_0000);
        send_request(OP_INC, 32'h0800_0000);
        test_random_traffic(400);
    endtask

    // Window ending in a partial page just below the top of the address space.
    task automatic test_high_window();
        stage_write(REG_MEM_BASE, 32'hFFF0_0000);
        commit_writes();
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_INC, 32'hFFFF_F000);     // partial page is not managed
        send_request(OP_FREE, 32'hFFFF_E000);
        send_request(OP_DEC, 32'hFFFF_EFFF);
        test_random_traffic(300);
    endtask

    // Three pages, two of them reserved; the stack runs dry quickly.
    task automatic test_tiny_window();
        stage_write(REG_KERNEL_END, 32'hFFF0_1000);
        stage_write(REG_FREE_START, 32'hFFF0_1800);
        stage_write(REG_UNMAPPED, 32'h1234_5678);
        stage_write(REG_MEM_TOP, 32'hFFF0_3100);
        commit_writes();
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'h0);           // out of pages
        send_request(OP_FREE, 32'hFFF0_2000);
        send_request(OP_FREE, 32'hFFF0_1000);    // reserved page released
        send_request(OP_FREE, 32'hFFF0_0000);    // below kernel_end
        send_request(OP_FREE, 32'hFFF0_3000);
        send_request(OP_INC, 32'hFFF0_30FF);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'h0);
        test_random_traffic(100);
    endtask

    // Registers at the opposite extremes: no page is managed at all.
    task automatic test_empty_window();
        stage_write(REG_MEM_BASE, 32'hFFFF_FFFF);
        stage_write(REG_KERNEL_END, 32'hFFFF_FFFF);
        stage_write(REG_FREE_START, 32'hFFFF_FFFF);
        stage_write(REG_MEM_TOP, 32'h0000_0000);
        commit_writes();
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_INC, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_DEC, 32'h0000_0000);
        test_random_traffic(30);
    endtask

    initial
    begin
        win_base   = MEM_BASE_RST;
        win_kernel = KERNEL_END_RST;
        win_free   = FREE_START_RST;
        win_top    = MEM_TOP_RST;
        rebuild_tables();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_random_traffic(600);
        test_count_saturation();
        test_full_window();
        test_high_window();
        test_tiny_window();
        test_empty_window();

        drain_results();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0)
            $display("refcounted_page_allocator_unit_tb: done, clean");
        else
            $display("refcounted_page_allocator_unit_tb: done, errors");
        $finish;
    end

    // Each mapped register write costs a full table sweep and the saturation test
    // runs tens of thousands of requests; this bound sits far beyond both.
    initial
    begin
        #30_000_000;
        $display("refcounted_page_allocator_unit_tb: done, errors");
        $finish;
    end

endmodule
